// ===== rtl/csts_pkg.sv =====
// csts_pkg: shared types and constants for the cubic spline tangent sampler
// used by csts_ctrl, csts_datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csts_pkg;

	// restoring divider steps for 2^17 / (2d)
	localparam int unsigned DIV_STEPS = 18;
	localparam logic [16:0] T_ONE = 17'h10000;
	localparam logic [6:0] SPP_RESET = 7'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic load_knot;
		logic start_div;
		logic step;
		logic issue;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic stall;
		logic pipe_empty;
		logic j_zero;
		logic j_last;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/csts_ctrl.sv =====
// csts_ctrl: sequencer for one knot (divide, issue samples, drain)
// depends on csts_pkg; drives csts_datapath through cmd_t / status_t
`timescale 1ns / 1ps
`default_nettype none

module csts_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire                  start_curve,
	input  csts_pkg::status_t    status,
	output csts_pkg::cmd_t       cmd
);

	csts_pkg::state_t state_q, state_d;
	logic have_prev_q;
	logic first_done_q;
	logic skip_q;
	logic accept;
	logic segment;

	assign accept  = s_tvalid && s_tready;
	assign segment = !start_curve && have_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= csts_pkg::ST_IDLE;
			have_prev_q  <= 1'b0;
			first_done_q <= 1'b0;
			skip_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				have_prev_q  <= 1'b1;
				first_done_q <= segment;
				skip_q       <= first_done_q;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			csts_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_knot = 1'b1;
					if (segment) begin
						cmd.start_div = 1'b1;
						state_d       = csts_pkg::ST_DIV;
					end
				end
			end
			csts_pkg::ST_DIV: begin
				if (status.div_done)
					state_d = csts_pkg::ST_RUN;
			end
			csts_pkg::ST_RUN: begin
				if (!status.stall) begin
					cmd.step  = 1'b1;
					// later segments drop the shared knot at j = 0
					cmd.issue = !(status.j_zero && skip_q);
					cmd.last  = status.j_last;
					if (status.j_last)
						state_d = csts_pkg::ST_DRAIN;
				end
			end
			csts_pkg::ST_DRAIN: begin
				if (status.pipe_empty)
					state_d = csts_pkg::ST_IDLE;
			end
			default: state_d = csts_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/csts_datapath.sv =====
// csts_datapath: knot registers, t/u steppers with divider, weight and
// blend pipeline, output register; depends on csts_pkg
`timescale 1ns / 1ps
`default_nettype none

module csts_datapath #(
	parameter int MAX_SAMPLES = 64,
	parameter int COORD_WIDTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	input  wire  [6:0]                   cfg_data,
	input  wire  signed [COORD_WIDTH-1:0] point_x,
	input  wire  signed [COORD_WIDTH-1:0] point_y,
	input  wire  signed [COORD_WIDTH-1:0] tangent_x,
	input  wire  signed [COORD_WIDTH-1:0] tangent_y,
	input  csts_pkg::cmd_t               cmd,
	output csts_pkg::status_t            status,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic signed [COORD_WIDTH-1:0] sample_x,
	output logic signed [COORD_WIDTH-1:0] sample_y,
	output logic                         m_tlast
);

	localparam int CW = COORD_WIDTH;
	localparam int DW = $clog2(MAX_SAMPLES);
	localparam int PW = CW + 19;
	localparam int AW = PW + 2;
	localparam logic signed [AW-17:0] OUT_MAX = (AW-16)'((1 <<< (CW-1)) - 1);
	localparam logic signed [AW-17:0] OUT_MIN = ~OUT_MAX;

	function automatic logic [16:0] rnd_w(input logic [52:0] x);
		logic [52:0] r;
		r = x + 53'h80000000;
		return r[48:32];
	endfunction

	// sample count register and clamp
	logic [6:0] spp_q;
	logic [31:0] s_cl;
	logic [DW-1:0] d_next, d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			spp_q <= csts_pkg::SPP_RESET;
		else if (cfg_valid)
			spp_q <= cfg_data;
	end

	always_comb begin
		if (spp_q < 7'd2)
			s_cl = 32'd2;
		else if (32'(spp_q) > 32'(MAX_SAMPLES))
			s_cl = 32'(MAX_SAMPLES);
		else
			s_cl = 32'(spp_q);
		d_next = DW'(s_cl - 32'd1);
	end

	// knots and control points
	logic signed [CW-1:0] ppx_q, ppy_q, pvx_q, pvy_q;
	logic signed [CW:0] c0x_q, c1x_q, c2x_q, c3x_q;
	logic signed [CW:0] c0y_q, c1y_q, c2y_q, c3y_q;

	always_ff @(posedge clk) begin
		if (cmd.load_knot) begin
			c0x_q <= (CW+1)'(ppx_q);
			c0y_q <= (CW+1)'(ppy_q);
			c1x_q <= (CW+1)'(ppx_q) + (CW+1)'(pvx_q);
			c1y_q <= (CW+1)'(ppy_q) + (CW+1)'(pvy_q);
			c2x_q <= (CW+1)'(point_x) - (CW+1)'(tangent_x);
			c2y_q <= (CW+1)'(point_y) - (CW+1)'(tangent_y);
			c3x_q <= (CW+1)'(point_x);
			c3y_q <= (CW+1)'(point_y);
			d_q   <= d_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppx_q <= '0;
			ppy_q <= '0;
			pvx_q <= '0;
			pvy_q <= '0;
		end else if (cmd.load_knot) begin
			ppx_q <= point_x;
			ppy_q <= point_y;
			pvx_q <= tangent_x;
			pvy_q <= tangent_y;
		end
	end

	// divider: Q = 2^17 / (2d), R = 2^17 mod (2d), one bit per cycle
	logic [DW+1:0] d2;
	logic [DW+1:0] rem_q, rem_sh, rem_n;
	logic [17:0] dvd_q;
	logic [16:0] quo_q;
	logic qbit;
	logic [4:0] dcnt_q;
	logic [DW:0] r_step;

	assign d2     = {1'b0, d_q, 1'b0};
	assign rem_sh = {rem_q[DW:0], dvd_q[17]};
	assign r_step = rem_q[DW:0];

	always_comb begin
		qbit  = 1'b0;
		rem_n = rem_sh;
		if (rem_sh >= d2) begin
			rem_n = rem_sh - d2;
			qbit  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dcnt_q <= '0;
		else if (cmd.start_div)
			dcnt_q <= 5'(csts_pkg::DIV_STEPS);
		else if (dcnt_q != '0)
			dcnt_q <= dcnt_q - 5'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q <= '0;
			dvd_q <= 18'h20000;
			quo_q <= '0;
		end else if (dcnt_q != '0) begin
			rem_q <= rem_n;
			dvd_q <= {dvd_q[16:0], 1'b0};
			quo_q <= {quo_q[15:0], qbit};
		end
	end

	// t rises from 0, u falls from one, both exact rounded quotients
	logic [16:0] ta_q, tu_q;
	logic [DW:0] ra_q, ru_q;
	logic [DW+1:0] ra_sum;
	logic [DW+2:0] ru_dif;
	logic [DW-1:0] j_q;

	assign ra_sum = {1'b0, ra_q} + {1'b0, r_step};
	assign ru_dif = {2'b0, ru_q} - {2'b0, r_step};

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			ta_q <= '0;
			ra_q <= {1'b0, d_next};
			tu_q <= csts_pkg::T_ONE;
			ru_q <= {1'b0, d_next};
			j_q  <= '0;
		end else if (cmd.step) begin
			j_q <= j_q + DW'(1);
			if (ra_sum >= d2) begin
				ra_q <= DW'(0) + (DW+1)'(ra_sum - d2);
				ta_q <= ta_q + quo_q + 17'd1;
			end else begin
				ra_q <= (DW+1)'(ra_sum);
				ta_q <= ta_q + quo_q;
			end
			if (ru_dif[DW+2]) begin
				ru_q <= (DW+1)'(ru_dif + {1'b0, d2});
				tu_q <= tu_q - quo_q - 17'd1;
			end else begin
				ru_q <= (DW+1)'(ru_dif);
				tu_q <= tu_q - quo_q;
			end
		end
	end

	// sample pipeline, frozen as a whole while the output beat waits
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic l_s1, l_s2, l_s3, l_s4, l_s5;
	logic [16:0] t_s1, u_s1, t_s2, u_s2;
	logic [33:0] uu_s2, tt_s2;
	logic [50:0] p0_s3, p1_s3, p2_s3, p3_s3;
	logic [16:0] w0_s4, w1_s4, w2_s4, w3_s4;
	logic signed [PW-1:0] mx0_s5, mx1_s5, mx2_s5, mx3_s5;
	logic signed [PW-1:0] my0_s5, my1_s5, my2_s5, my3_s5;
	logic signed [AW-1:0] accx, accy;
	logic signed [AW-17:0] shx, shy;
	logic signed [CW-1:0] satx, saty;

	assign en = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= cmd.issue;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			m_tvalid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= ta_q;
			u_s1  <= tu_q;
			l_s1  <= cmd.last;
			t_s2  <= t_s1;
			u_s2  <= u_s1;
			uu_s2 <= u_s1 * u_s1;
			tt_s2 <= t_s1 * t_s1;
			l_s2  <= l_s1;
			p0_s3 <= uu_s2 * u_s2;
			p1_s3 <= uu_s2 * t_s2;
			p2_s3 <= tt_s2 * u_s2;
			p3_s3 <= tt_s2 * t_s2;
			l_s3  <= l_s2;
			w0_s4 <= rnd_w(53'(p0_s3));
			w1_s4 <= rnd_w({1'b0, p1_s3, 1'b0} + 53'(p1_s3));
			w2_s4 <= rnd_w({1'b0, p2_s3, 1'b0} + 53'(p2_s3));
			w3_s4 <= rnd_w(53'(p3_s3));
			l_s4  <= l_s3;
			mx0_s5 <= $signed({1'b0, w0_s4}) * c0x_q;
			mx1_s5 <= $signed({1'b0, w1_s4}) * c1x_q;
			mx2_s5 <= $signed({1'b0, w2_s4}) * c2x_q;
			mx3_s5 <= $signed({1'b0, w3_s4}) * c3x_q;
			my0_s5 <= $signed({1'b0, w0_s4}) * c0y_q;
			my1_s5 <= $signed({1'b0, w1_s4}) * c1y_q;
			my2_s5 <= $signed({1'b0, w2_s4}) * c2y_q;
			my3_s5 <= $signed({1'b0, w3_s4}) * c3y_q;
			l_s5  <= l_s4;
			if (v_s5) begin
				sample_x <= satx;
				sample_y <= saty;
				m_tlast  <= l_s5;
			end
		end
	end

	// round half up at 2^-16, then saturate
	always_comb begin
		accx = AW'(mx0_s5) + AW'(mx1_s5) + AW'(mx2_s5) + AW'(mx3_s5)
			+ AW'(32'sd32768);
		accy = AW'(my0_s5) + AW'(my1_s5) + AW'(my2_s5) + AW'(my3_s5)
			+ AW'(32'sd32768);
		shx = accx[AW-1:16];
		shy = accy[AW-1:16];
		if (shx > OUT_MAX)
			satx = {1'b0, {(CW-1){1'b1}}};
		else if (shx < OUT_MIN)
			satx = {1'b1, {(CW-1){1'b0}}};
		else
			satx = shx[CW-1:0];
		if (shy > OUT_MAX)
			saty = {1'b0, {(CW-1){1'b1}}};
		else if (shy < OUT_MIN)
			saty = {1'b1, {(CW-1){1'b0}}};
		else
			saty = shy[CW-1:0];
	end

	always_comb begin
		status.div_done   = (dcnt_q == '0);
		status.stall      = !en;
		status.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || m_tvalid);
		status.j_zero     = (j_q == '0);
		status.j_last     = (j_q == d_q);
	end

endmodule

`default_nettype wire

// ===== rtl/cubic_spline_tangent_sampler.sv =====
// cubic_spline_tangent_sampler: top level, joins csts_ctrl and csts_datapath
// depends on csts_pkg, csts_ctrl, csts_datapath
//
// Knots come in on the s_ channel, one beat per knot, with the start flag in
// s_tuser. A knot that follows another knot of the same curve yields one
// cubic Bezier segment sampled at t = j/(S-1); the first segment of a curve
// gives S beats, later ones S-1, and m_tlast marks the final beat of a knot.
// Start knots, and the first knot after reset, only load state.
// The divider first forms the t step, then one sample is issued per cycle,
// while the output is not stalled, into a six-stage weight and blend
// pipeline. A new knot is taken only after the previous one has fully
// drained. A start knot does not leave the idle state.
// S comes from the cfg_ channel (reset 16), clamped to 2..MAX_SAMPLES, and is
// sampled when a knot is taken. Reset clears the previous knot and flags.
// While a beat waits on m_tready, the whole sample pipeline holds its beats.
`timescale 1ns / 1ps
`default_nettype none

module cubic_spline_tangent_sampler #(
	parameter int MAX_SAMPLES = 64,
	parameter int COORD_WIDTH = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [6:0]                          cfg_data,   // samples_per_piece
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// point_x, point_y, tangent_x, tangent_y
	input  wire  [((4*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
	input  wire                                 s_tuser,    // start_curve
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// sample_x, sample_y
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
	output logic                                m_tlast     // last_of_segment
);

	localparam int CW   = COORD_WIDTH;
	localparam int OUTW = ((2*COORD_WIDTH+7)/8)*8;

	csts_pkg::cmd_t    cmd;
	csts_pkg::status_t status;
	logic signed [CW-1:0] sample_x, sample_y;

	assign cfg_ready = 1'b1;

	csts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.start_curve (s_tuser),
		.status      (status),
		.cmd         (cmd)
	);

	csts_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.point_x   (s_tdata[CW-1:0]),
		.point_y   (s_tdata[2*CW-1:CW]),
		.tangent_x (s_tdata[3*CW-1:2*CW]),
		.tangent_y (s_tdata[4*CW-1:3*CW]),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.sample_x  (sample_x),
		.sample_y  (sample_y),
		.m_tlast   (m_tlast)
	);

	assign m_tdata = OUTW'({sample_y, sample_x});

	// a knot is only taken once every sample of the previous one is out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !m_tvalid)
		else $error("knot accepted while samples pending");

	// a start knot emits nothing and frees the input at once
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> s_tready && !m_tvalid)
		else $error("start knot did not return to idle");

	// output beats appear only while the input side is closed
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("sample emitted while idle");

endmodule

`default_nettype wire

// ===== tb/csts_checker.sv =====
// csts_checker: watches the cfg_, s_ and m_ channels of the spline sampler,
// predicts every sample beat and compares it with what the block emits
// depends on nothing but the ports of cubic_spline_tangent_sampler
`timescale 1ns / 1ps

module csts_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [6:0]  cfg_data,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [63:0] s_tdata,
	input  wire         s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [31:0] m_tdata,
	input  wire         m_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
	} sample_t;

	sample_t samples_due[$];

	logic [6:0]          spp;
	logic signed [15:0]  knot_px, knot_py, knot_vx, knot_vy;
	logic                have_knot;
	logic                first_done;

	function automatic longint t_pos(longint j, longint d);
		return (j * 65536 * 2 + d) / (2 * d);
	endfunction

	function automatic longint rnd32(longint v);
		return (v + (longint'(1) << 31)) >>> 32;
	endfunction

	function automatic logic signed [15:0] clip16(longint acc);
		longint v;
		v = (acc + 32768) >>> 16;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// expand one segment into its sample beats
	task automatic predict_segment(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] vx, logic signed [15:0] vy);
		longint s, d, t, u, ax, ay;
		longint w[4], cx[4], cy[4];
		sample_t smp;
		s = spp;
		if (s < 2) s = 2;
		if (s > 64) s = 64;
		d = s - 1;
		cx[0] = knot_px;
		cy[0] = knot_py;
		cx[1] = longint'(knot_px) + longint'(knot_vx);
		cy[1] = longint'(knot_py) + longint'(knot_vy);
		cx[2] = longint'(px) - longint'(vx);
		cy[2] = longint'(py) - longint'(vy);
		cx[3] = px;
		cy[3] = py;
		for (longint j = first_done ? 1 : 0; j < s; j++) begin
			t = t_pos(j, d);
			u = t_pos(d - j, d);
			w[0] = rnd32(u * u * u);
			w[1] = rnd32(3 * u * u * t);
			w[2] = rnd32(3 * u * t * t);
			w[3] = rnd32(t * t * t);
			ax = 0;
			ay = 0;
			for (int k = 0; k < 4; k++) begin
				ax += w[k] * cx[k];
				ay += w[k] * cy[k];
			end
			smp.x = clip16(ax);
			smp.y = clip16(ay);
			smp.last = (j == d);
			samples_due.insert(samples_due.size(), smp);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		int errs;
		errs = 0;
		if (!arst_n) begin
			spp <= 7'd16;
			knot_px <= '0;
			knot_py <= '0;
			knot_vx <= '0;
			knot_vy <= '0;
			have_knot <= 1'b0;
			first_done <= 1'b0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				spp <= cfg_data;
			if (s_tvalid && s_tready) begin
				if (!s_tuser && have_knot) begin
					predict_segment(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
						s_tdata[63:48]);
					first_done <= 1'b1;
				end else begin
					first_done <= 1'b0;
				end
				knot_px <= s_tdata[15:0];
				knot_py <= s_tdata[31:16];
				knot_vx <= s_tdata[47:32];
				knot_vy <= s_tdata[63:48];
				have_knot <= 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (samples_due.size() == 0) begin
					$error("unexpected sample beat x=%0d y=%0d", $signed(m_tdata[15:0]),
						$signed(m_tdata[31:16]));
					errs++;
				end else begin
					sample_t e;
					e = samples_due.pop_front();
					if (e.x !== m_tdata[15:0]) begin
						$error("sample_x expected %0d actual %0d", e.x, $signed(m_tdata[15:0]));
						errs++;
					end
					if (e.y !== m_tdata[31:16]) begin
						$error("sample_y expected %0d actual %0d", e.y, $signed(m_tdata[31:16]));
						errs++;
					end
					if (e.last !== m_tlast) begin
						$error("last_of_segment expected %0d actual %0d", e.last, m_tlast);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= samples_due.size();
		end
	end

endmodule

// ===== tb/cubic_spline_tangent_sampler_tb.sv =====
// cubic_spline_tangent_sampler_tb: drives knots and sample counts into the
// spline sampler with random gaps and stalls; depends on csts_checker and the rtl
`timescale 1ns / 1ps

module cubic_spline_tangent_sampler_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	int          fail_count;
	int          pending;
	logic        no_gaps = 1'b0;
	logic        no_stalls = 1'b0;

	always #4 clk = ~clk;

	cubic_spline_tangent_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	csts_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	task automatic send_knot(logic [15:0] px, logic [15:0] py, logic [15:0] vx,
			logic [15:0] vy, logic start);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {vy, vx, py, px};
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off until every sample has come, then let the pipeline settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_spp(logic [6:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(3))
			0: return 16'($urandom());
			1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(4000)) - 2000);
		endcase
	endfunction

	// downstream stalls, drawn per beat
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_stalls ? 0 : $urandom_range(15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [6:0] spp_list[6];
		int chain;
		spp_list = '{7'd2, 7'd64, 7'd3, 7'd63, 7'd5, 7'd16};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// knot with no previous one, then extremes at reset count
		send_knot(16'h0100, 16'hff00, 16'h0040, 16'h0020, 1'b0);
		send_knot(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
		send_knot(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0);
		send_knot(16'h0000, 16'h0000, 16'h8000, 16'h7fff, 1'b1);
		send_knot(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
		send_knot(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 1'b0);
		send_knot(16'h0010, 16'h0020, 16'h0000, 16'h0000, 1'b1);
		send_knot(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
		write_spp(7'd2);
		send_knot(16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0);
		send_knot(16'h1000, 16'h2000, 16'h0100, 16'hff00, 1'b0);
		write_spp(7'd64);
		send_knot(16'h2000, 16'h1000, 16'h0300, 16'h0200, 1'b0);
		send_knot(16'h3000, 16'h0000, 16'h7fff, 16'h8000, 1'b1);
		send_knot(16'h0000, 16'h3000, 16'h8000, 16'h7fff, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			write_spp(ph == 5 ? 7'($urandom_range(2, 64)) : spp_list[ph]);
			no_gaps = (ph == 2);
			no_stalls = (ph == 3);
			for (int n = 0; n < 42;) begin
				chain = $urandom_range(2, 8);
				if ($urandom_range(9) != 0) begin
					send_knot(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
					n++;
				end
				for (int c = 0; c < chain; c++)
					send_knot(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
						$urandom_range(11) == 0);
				n += chain;
			end
		end
		no_gaps = 1'b0;
		no_stalls = 1'b0;

		wait_drained();
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/csts_pkg.sv
rtl/csts_ctrl.sv
rtl/csts_datapath.sv
rtl/cubic_spline_tangent_sampler.sv
tb/csts_checker.sv
tb/cubic_spline_tangent_sampler_tb.sv
